FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console cell writer.
// Depends on nothing; every other file uses it.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CELL_IDX_W   = 11;
    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int STRIDE_W     = 5;
    localparam int CFG_DATA_W   = 8;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [STRIDE_W-1:0] MAX_STRIDE = 5'd16;
    localparam logic [ATTR_W-1:0]   ATTR_RESET   = 8'd7;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd4;

    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;

    localparam logic [CFG_INDEX_W-1:0] REG_ATTRIBUTE  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAB_STRIDE = 1'd1;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_PRINT,
        KIND_LF,
        KIND_CR,
        KIND_TAB,
        KIND_BS
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_TAB
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic tab_step;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic tab_start;
        logic tab_final;
    } status_t;

endpackage

FILE: rtl/tcw_if.sv
// Handshake channels of the text console cell writer: characters in, cell writes out.
// Depends on tcw_pkg for field widths.
interface tcw_char_if;
    logic                      valid;
    logic                      ready;
    logic [tcw_pkg::CHAR_W-1:0] char_code;
    logic                      raw;

    modport source (output valid, output char_code, output raw, input ready);
    modport sink   (input valid, input char_code, input raw, output ready);
endinterface

interface tcw_cell_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CELL_IDX_W-1:0] cell_index;
    logic [tcw_pkg::CHAR_W-1:0]     cell_char;
    logic [tcw_pkg::ATTR_W-1:0]     cell_attr;
    logic                          last;

    modport source (output valid, output cell_index, output cell_char, output cell_attr,
                    output last, input ready);
    modport sink   (input valid, input cell_index, input cell_char, input cell_attr,
                    input last, output ready);
endinterface

FILE: rtl/tcw_ctrl.sv
// Controller of the cell writer: decides when a character is taken and
// sequences the extra cell writes of a tab. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  tcw_pkg::status_t status,
    output tcw_pkg::cmd_t    cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.tab_start)
                begin
                    state_next = ST_TAB;
                end
            end
            ST_TAB:
            begin
                if (status.slot_free && status.tab_final)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = status.slot_free;
            end
            ST_TAB:
            begin
                cmd.tab_step = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/tcw_datapath.sv
// Datapath of the cell writer: cursor with column and row start, configuration
// registers, character decode and the output register. Depends on tcw_pkg and tcw_if.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    tcw_char_if.sink                         chars,
    tcw_cell_if.source                       cells,
    input  tcw_pkg::cmd_t                    cmd,
    output tcw_pkg::status_t                 status
);
    import tcw_pkg::*;

    localparam int BUF_CELLS = COLUMNS * ROWS;
    localparam int CW        = $clog2(BUF_CELLS + 1);
    localparam int COLW      = $clog2(COLUMNS);

    localparam logic [CW:0]     BUF_EXT   = (CW + 1)'(BUF_CELLS);
    localparam logic [CW-1:0]   BUF_END   = CW'(BUF_CELLS);
    localparam logic [CW-1:0]   COLS_CW   = CW'(COLUMNS);
    localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);

    logic [CW-1:0]       cursor_reg,    cursor_next;
    logic [COLW-1:0]     col_reg,       col_next;
    logic [CW-1:0]       row_start_reg, row_start_next;
    logic [ATTR_W-1:0]   attr_reg,      attr_next;
    logic [STRIDE_W-1:0] stride_reg,    stride_next;
    logic [STRIDE_W-1:0] remain_reg,    remain_next;
    logic                out_valid_reg, out_valid_next;
    logic [CELL_IDX_W-1:0] out_index_reg, out_index_next;
    logic [CHAR_W-1:0]   out_char_reg,  out_char_next;
    logic [ATTR_W-1:0]   out_attr_reg,  out_attr_next;
    logic                out_last_reg,  out_last_next;

    logic                  slot_free;
    logic                  accepted;
    kind_t                 kind;
    logic [STRIDE_W-1:0]   stride_sat;
    logic [CW:0]           next_row_ext;
    logic [CW:0]           tab_end_ext;
    logic [CW+CELL_IDX_W-1:0] cursor_wide;
    logic [CELL_IDX_W-1:0] cursor_index;
    logic [CW-1:0]         adv_cursor;
    logic [COLW-1:0]       adv_col;
    logic [CW-1:0]         adv_row_start;
    logic                  out_load;

    assign slot_free = !out_valid_reg || cells.ready;
    assign accepted  = chars.valid && cmd.in_ready;
    assign chars.ready = cmd.in_ready;

    assign stride_sat   = (stride_reg > MAX_STRIDE) ? MAX_STRIDE : stride_reg;
    assign next_row_ext = {1'b0, row_start_reg} + {1'b0, COLS_CW};
    assign tab_end_ext  = {1'b0, cursor_reg} + (CW + 1)'(stride_sat);
    assign cursor_wide  = {{CELL_IDX_W{1'b0}}, cursor_reg};
    assign cursor_index = cursor_wide[CELL_IDX_W-1:0];

    // One cell forward, keeping column and row start in step with the cursor.
    always_comb
    begin
        adv_cursor = cursor_reg + CW'(1);
        if (col_reg == COL_LAST)
        begin
            adv_col       = '0;
            adv_row_start = row_start_reg + COLS_CW;
        end
        else
        begin
            adv_col       = col_reg + COLW'(1);
            adv_row_start = row_start_reg;
        end
    end

    always_comb
    begin
        kind = KIND_PRINT;
        priority if (cursor_reg == BUF_END)
        begin
            kind = KIND_NONE;
        end
        else if (chars.raw)
        begin
            kind = KIND_PRINT;
        end
        else if (chars.char_code == CHAR_LF)
        begin
            kind = (next_row_ext < BUF_EXT) ? KIND_LF : KIND_NONE;
        end
        else if (chars.char_code == CHAR_CR)
        begin
            kind = KIND_CR;
        end
        else if (chars.char_code == CHAR_TAB)
        begin
            kind = (stride_sat != '0 && tab_end_ext < BUF_EXT) ? KIND_TAB : KIND_NONE;
        end
        else if (chars.char_code == CHAR_BS)
        begin
            kind = (cursor_reg != '0) ? KIND_BS : KIND_NONE;
        end
        else
        begin
            kind = KIND_PRINT;
        end
    end

    assign status.slot_free = slot_free;
    assign status.tab_start = accepted && (kind == KIND_TAB) && (stride_sat != STRIDE_W'(1));
    assign status.tab_final = (remain_reg == STRIDE_W'(1));

    always_comb
    begin
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        row_start_next = row_start_reg;
        remain_next    = remain_reg;
        out_load       = 1'b0;
        out_index_next = out_index_reg;
        out_char_next  = out_char_reg;
        out_attr_next  = out_attr_reg;
        out_last_next  = out_last_reg;

        if (cmd.tab_step)
        begin
            out_load       = 1'b1;
            out_index_next = cursor_index;
            out_char_next  = CHAR_SPACE;
            out_attr_next  = '0;
            out_last_next  = (remain_reg == STRIDE_W'(1));
            remain_next    = remain_reg - STRIDE_W'(1);
            cursor_next    = adv_cursor;
            col_next       = adv_col;
            row_start_next = adv_row_start;
        end
        else if (accepted)
        begin
            out_index_next = cursor_index;
            out_char_next  = CHAR_NUL;
            out_attr_next  = '0;
            out_last_next  = 1'b1;
            unique case (kind)
                KIND_NONE:
                begin
                    out_load = 1'b0;
                end
                KIND_PRINT:
                begin
                    out_load       = 1'b1;
                    out_char_next  = chars.char_code;
                    out_attr_next  = attr_reg;
                    cursor_next    = adv_cursor;
                    col_next       = adv_col;
                    row_start_next = adv_row_start;
                end
                KIND_LF:
                begin
                    out_load       = 1'b1;
                    cursor_next    = next_row_ext[CW-1:0];
                    col_next       = '0;
                    row_start_next = next_row_ext[CW-1:0];
                end
                KIND_CR:
                begin
                    out_load    = 1'b1;
                    cursor_next = row_start_reg;
                    col_next    = '0;
                end
                KIND_TAB:
                begin
                    out_load       = 1'b1;
                    out_char_next  = CHAR_SPACE;
                    out_last_next  = (stride_sat == STRIDE_W'(1));
                    remain_next    = stride_sat - STRIDE_W'(1);
                    cursor_next    = adv_cursor;
                    col_next       = adv_col;
                    row_start_next = adv_row_start;
                end
                KIND_BS:
                begin
                    out_load    = 1'b1;
                    cursor_next = cursor_reg - CW'(1);
                    if (col_reg == '0)
                    begin
                        col_next       = COL_LAST;
                        row_start_next = row_start_reg - COLS_CW;
                    end
                    else
                    begin
                        col_next = col_reg - COLW'(1);
                    end
                end
                default:
                begin
                    out_load = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (cells.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_comb
    begin
        attr_next   = attr_reg;
        stride_next = stride_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ATTRIBUTE:  attr_next   = cfg_data[ATTR_W-1:0];
                REG_TAB_STRIDE: stride_next = cfg_data[STRIDE_W-1:0];
                default:        attr_next   = attr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            row_start_reg <= '0;
            attr_reg      <= ATTR_RESET;
            stride_reg    <= STRIDE_RESET;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            row_start_reg <= row_start_next;
            attr_reg      <= attr_next;
            stride_reg    <= stride_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg <= out_index_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
        out_last_reg  <= out_last_next;
    end

    assign cells.valid      = out_valid_reg;
    assign cells.cell_index = out_index_reg;
    assign cells.cell_char  = out_char_reg;
    assign cells.cell_attr  = out_attr_reg;
    assign cells.last       = out_last_reg;

endmodule

FILE: rtl/text_console_cell_writer.sv
// Top level of the text console cell writer: controller plus datapath.
// Depends on tcw_pkg, tcw_if, tcw_ctrl and tcw_datapath.
//
//   Channel  Direction  Transaction
//   chars    in         one character byte and its raw flag
//   cells    out        one cell write: index, character, attribute, last flag
//   cfg      in         one register write (attribute, tab_stride)
//
// A character that writes one cell writes it once; a tab writes one space cell per cell
// of its stride, up to 16. All writes pass through the single output register.
// The next character is taken once no tab is in progress and that register is empty or is read in the same cycle.
// Reset puts the cursor at cell 0, the attribute at 7 and the tab stride at 4.
// A stall on cells holds the pending write and stops further input.
module text_console_cell_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
    tcw_char_if.sink                        chars,
    tcw_cell_if.source                      cells
);
    import tcw_pkg::*;

    cmd_t    cmd;
    status_t status;

    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (chars),
        .cells     (cells),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
